// ===== rtl/core/rfid_ascii_hex_frame_matcher_core_defines.svh =====
// assertion macros used by the frame matcher checker
`ifndef RFID_ASCII_HEX_FRAME_MATCHER_CORE_DEFINES_SVH
`define RFID_ASCII_HEX_FRAME_MATCHER_CORE_DEFINES_SVH

// same-cycle implication, sampled on the rising clock, quiet in reset
`define RFIDHX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfidhx same-cycle check failed");

// next-cycle implication, sampled on the rising clock, quiet in reset
`define RFIDHX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfidhx next-cycle check failed");

`endif

// ===== rtl/core/rfidhx_pkg.sv =====
// shared types and constants of the rfid ascii hex frame matcher
package rfidhx_pkg;

  localparam int TAG_W            = 40;
  localparam int BYTE_W           = 8;
  localparam int CNT_W            = 3;
  localparam int IDX_W            = 3;
  localparam int DCNT_W           = 4;
  localparam int CFG_IDX_W        = 3;
  localparam int NUM_TAG_REGS     = 4;
  localparam int DIGITS_PER_FRAME = 12;
  localparam int TAG_DIGITS       = 10;

  // framing and digit codes
  localparam logic [BYTE_W-1:0] ASCII_STX  = 8'h02;
  localparam logic [BYTE_W-1:0] ASCII_ETX  = 8'h03;
  localparam logic [BYTE_W-1:0] ASCII_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] ASCII_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_NINE = 8'h39;
  localparam logic [BYTE_W-1:0] ASCII_A_UP = 8'h41;
  localparam logic [BYTE_W-1:0] ASCII_F_UP = 8'h46;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAG_COUNT = 3'd0,
    CFG_TAG_A     = 3'd1,
    CFG_TAG_B     = 3'd2,
    CFG_TAG_C     = 3'd3,
    CFG_TAG_D     = 3'd4
  } cfg_reg_e;

  localparam logic [CNT_W-1:0] TAG_COUNT_RESET = 3'd4;
  localparam logic [TAG_W-1:0] TAG_RESET [NUM_TAG_REGS] = '{
    40'h0100C1A6B3, 40'h0100C216B5, 40'h0100C201E5, 40'h0100C20086
  };

  // what the frame parser reports for one item
  typedef struct packed {
    logic                done;
    logic [TAG_W-1:0]    tag;
    logic [BYTE_W-1:0]   check;
    logic                check_ok;
    logic                bad;
  } frame_res_t;

endpackage

// ===== rtl/core/rfidhx_frame.sv =====
// frame parser: header hunt, hex digit decode, tag and checksum assembly
module rfidhx_frame
  import rfidhx_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [BYTE_W-1:0] byte_i,
  output frame_res_t        res_o
);

  logic              in_frame_q, in_frame_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [3:0]        high_q, high_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [BYTE_W-1:0] check_q, check_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              bad_q, bad_d;

  logic [3:0]        nib;
  logic              ok_digit;
  logic [BYTE_W-1:0] pair;
  logic              is_term;
  logic              last_digit;

  // upper-case hex decode, anything else reads as zero and flags an error
  always_comb begin
    nib      = 4'd0;
    ok_digit = 1'b0;
    if (byte_i inside {[ASCII_ZERO:ASCII_NINE]}) begin
      nib      = 4'(byte_i - ASCII_ZERO);
      ok_digit = 1'b1;
    end else if (byte_i inside {[ASCII_A_UP:ASCII_F_UP]}) begin
      nib      = 4'(byte_i - ASCII_A_UP) + 4'd10;
      ok_digit = 1'b1;
    end
  end

  assign pair       = {high_q, nib};
  assign is_term    = byte_i inside {ASCII_CR, ASCII_LF, ASCII_ETX, ASCII_STX};
  assign last_digit = cnt_q == DCNT_W'(DIGITS_PER_FRAME - 1);

  // frame state update
  always_comb begin
    in_frame_d = in_frame_q;
    cnt_d      = cnt_q;
    high_d     = high_q;
    tag_d      = tag_q;
    check_d    = check_q;
    xor_d      = xor_q;
    bad_d      = bad_q;
    if (step_i) begin
      if (!in_frame_q || is_term || last_digit) begin
        // header, abort or frame end all start from a clean frame
        in_frame_d = !in_frame_q && (byte_i == ASCII_STX);
        cnt_d      = '0;
        high_d     = '0;
        tag_d      = '0;
        check_d    = '0;
        xor_d      = '0;
        bad_d      = 1'b0;
      end else begin
        bad_d = bad_q | !ok_digit;
        cnt_d = cnt_q + DCNT_W'(1);
        if (!cnt_q[0]) begin
          high_d = nib;
        end else if (cnt_q < DCNT_W'(TAG_DIGITS)) begin
          tag_d = {tag_q[TAG_W-BYTE_W-1:0], pair};
          xor_d = xor_q ^ pair;
        end else begin
          check_d = pair;
        end
      end
    end
  end

  // twelfth digit completes the frame; the tag is already whole by then
  always_comb begin
    res_o.done     = step_i && in_frame_q && !is_term && last_digit;
    res_o.tag      = tag_q;
    res_o.check    = pair;
    res_o.check_ok = xor_q == pair;
    res_o.bad      = bad_q | !ok_digit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      cnt_q      <= '0;
      high_q     <= '0;
      tag_q      <= '0;
      check_q    <= '0;
      xor_q      <= '0;
      bad_q      <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
      cnt_q      <= cnt_d;
      high_q     <= high_d;
      tag_q      <= tag_d;
      check_q    <= check_d;
      xor_q      <= xor_d;
      bad_q      <= bad_d;
    end
  end

endmodule

// ===== rtl/core/rfidhx_match.sv =====
// table lookup: first enabled entry equal to the tag, 1-based
module rfidhx_match
  import rfidhx_pkg::*;
#(
  parameter int USED = 4
) (
  input  logic [TAG_W-1:0]           tag_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [USED-1:0][TAG_W-1:0] entries_i,
  output logic [IDX_W-1:0]           idx_o
);

  // parallel compares, lowest entry wins
  always_comb begin
    idx_o = '0;
    for (int i = USED - 1; i >= 0; i--) begin
      if (count_i > CNT_W'(i) && entries_i[i] == tag_i) begin
        idx_o = IDX_W'(i + 1);
      end
    end
  end

endmodule

// ===== rtl/core/rfid_ascii_hex_frame_matcher_core.sv =====
// top level of the rfid ascii hex frame matcher
// a result is loaded as its last digit leaves the input register
// throughput: one item per cycle unless stalled, set by the single input register
// ahead of the parser; it stalls only while a done result waits in the result register
// reset clears the frame state and the valid bits of both registers, tag_count reads 4
// reset loads the default tag table; no clearing pass is needed
module rfid_ascii_hex_frame_matcher_core
  import rfidhx_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [TAG_W-1:0]     tag_value_o,
  output logic [BYTE_W-1:0]    received_check_o,
  output logic                 check_ok_o,
  output logic [IDX_W-1:0]     match_index_o,
  output logic                 digit_error_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TAG_W-1:0]     cfg_data_i
);

  localparam int USED = (TABLE_ENTRIES < NUM_TAG_REGS) ? TABLE_ENTRIES : NUM_TAG_REGS;

  logic                      in_vld_q;
  logic [BYTE_W-1:0]         in_byte_q;
  logic                      in_accept;
  logic                      advance;
  logic [CNT_W-1:0]          count_q;
  logic [USED-1:0][TAG_W-1:0] entries_q;
  frame_res_t                frame_res;
  logic [IDX_W-1:0]          match_idx;
  logic                      load_res;
  logic                      out_vld_d;

  // handshake: the input register moves on whenever the result slot can take a result
  assign advance    = in_vld_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load_res   = advance && frame_res.done;
  assign out_vld_d  = load_res || (out_valid_o && out_stall_i);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept || advance) begin
      in_vld_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_byte_q <= rx_byte_i;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= TAG_COUNT_RESET;
      for (int i = 0; i < USED; i++) begin
        entries_q[i] <= TAG_RESET[i];
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_TAG_COUNT) begin
        count_q <= cfg_data_i[CNT_W-1:0];
      end
      for (int i = 0; i < USED; i++) begin
        if (cfg_idx_i == 3'(CFG_TAG_A) + 3'(i)) begin
          entries_q[i] <= cfg_data_i;
        end
      end
    end
  end

  rfidhx_frame u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (frame_res)
  );

  rfidhx_match #(
    .USED (USED)
  ) u_match (
    .tag_i     (frame_res.tag),
    .count_i   (count_q),
    .entries_i (entries_q),
    .idx_o     (match_idx)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else begin
      out_valid_o <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      tag_value_o      <= frame_res.tag;
      received_check_o <= frame_res.check;
      check_ok_o       <= frame_res.check_ok;
      match_index_o    <= frame_res.bad ? '0 : match_idx;
      digit_error_o    <= frame_res.bad;
    end
  end

endmodule

// ===== rtl/core/rfidhx_checker.sv =====
// port-level checker for the frame matcher, bound to the top level
`include "rfid_ascii_hex_frame_matcher_core_defines.svh"

module rfidhx_checker
  import rfidhx_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [TAG_W-1:0]     tag_value_o,
  input logic [IDX_W-1:0]     match_index_o,
  input logic                 digit_error_o
);

  // a bad digit never yields a match
  `RFIDHX_ASSERT_NOW(a_err_no_match, out_valid_o && digit_error_o, match_index_o == '0)
  // match index stays within the table
  `RFIDHX_ASSERT_NOW(a_idx_range, out_valid_o, match_index_o <= IDX_W'(NUM_TAG_REGS))
  // input side backs up only behind a held result
  `RFIDHX_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i)
  // a held result keeps its tag
  `RFIDHX_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(tag_value_o))

endmodule

bind rfid_ascii_hex_frame_matcher_core rfidhx_checker u_rfidhx_checker (.*);

// ===== bench/rfid_ascii_hex_frame_matcher_core_tb.sv =====
// testbench for the rfid ascii hex frame matcher: frame predictor, drivers and table phases
module rfid_ascii_hex_frame_matcher_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfidhx_pkg::*;

  localparam int TABLE_ENTRIES = 4;
  localparam int PHASE_BYTES   = 235;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 250000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX = '1;
  localparam logic [BYTE_W-1:0] ASCII_A_LO = 8'h61;
  localparam logic [BYTE_W-1:0] ASCII_F_LO = 8'h66;
  localparam logic [BYTE_W-1:0] FRAME_STOPS [4] = '{ASCII_CR, ASCII_LF, ASCII_ETX, ASCII_STX};

  typedef struct packed {
    logic [TAG_W-1:0]  tag_value;
    logic [BYTE_W-1:0] received_check;
    logic              check_ok;
    logic [IDX_W-1:0]  match_index;
    logic              digit_error;
  } tag_report_t;

  // frame decoder and tag table mirror, holds the reports still to come
  class frame_scoreboard;
    logic [CNT_W-1:0]  tag_count;
    logic [TAG_W-1:0]  allowed [NUM_TAG_REGS];
    bit                in_frame;
    logic [DCNT_W-1:0] digit_count;
    logic [3:0]        high_nib;
    logic [TAG_W-1:0]  tag_acc;
    logic [BYTE_W-1:0] check_acc;
    logic [BYTE_W-1:0] xor_acc;
    bit                bad_seen;
    tag_report_t       pending_reports [$];
    int unsigned       errors, reports_seen, matched, bad_check, digit_errs, aborts;

    function new();
      tag_count = TAG_COUNT_RESET;
      allowed   = TAG_RESET;
      errors = 0;
      reports_seen = 0;
      matched = 0;
      bad_check = 0;
      digit_errs = 0;
      aborts = 0;
      drop_frame();
    endfunction

    function void drop_frame();
      in_frame    = 1'b0;
      digit_count = '0;
      high_nib    = '0;
      tag_acc     = '0;
      check_acc   = '0;
      xor_acc     = '0;
      bad_seen    = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TAG_W-1:0] data);
      case (idx)
        CFG_TAG_COUNT: tag_count = data[CNT_W-1:0];
        CFG_TAG_A:     allowed[0] = data;
        CFG_TAG_B:     allowed[1] = data;
        CFG_TAG_C:     allowed[2] = data;
        CFG_TAG_D:     allowed[3] = data;
        default:       ;
      endcase
    endfunction

    // one accepted byte; a twelfth digit yields a report
    function void note_byte(logic [BYTE_W-1:0] b);
      logic [3:0]        nib;
      logic [BYTE_W-1:0] pair;
      tag_report_t       r;
      int                n;
      if (!in_frame) begin
        if (b == ASCII_STX) begin
          drop_frame();
          in_frame = 1'b1;
        end
        return;
      end
      // any framing byte inside a frame kills it
      if (b == ASCII_CR || b == ASCII_LF || b == ASCII_ETX || b == ASCII_STX) begin
        drop_frame();
        aborts++;
        return;
      end
      if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
        nib = 4'(b - ASCII_ZERO);
      end else if (b >= ASCII_A_UP && b <= ASCII_F_UP) begin
        nib = 4'(b - ASCII_A_UP + 8'd10);
      end else begin
        nib = '0;
        bad_seen = 1'b1;
      end
      if (!digit_count[0]) begin
        high_nib = nib;
      end else begin
        pair = {high_nib, nib};
        if (digit_count < TAG_DIGITS) begin
          tag_acc = {tag_acc[TAG_W-BYTE_W-1:0], pair};
          xor_acc = xor_acc ^ pair;
        end else begin
          check_acc = pair;
        end
      end
      digit_count++;
      if (digit_count == DIGITS_PER_FRAME) begin
        r.tag_value      = tag_acc;
        r.received_check = check_acc;
        r.check_ok       = (xor_acc == check_acc);
        r.digit_error    = bad_seen;
        r.match_index    = '0;
        if (!bad_seen) begin
          n = int'(tag_count);
          if (n > TABLE_ENTRIES) n = TABLE_ENTRIES;
          if (n > NUM_TAG_REGS) n = NUM_TAG_REGS;
          // scan downwards so the lowest matching entry wins
          for (int i = n - 1; i >= 0; i--) begin
            if (allowed[i] == tag_acc) r.match_index = IDX_W'(i + 1);
          end
        end
        pending_reports.push_back(r);
        drop_frame();
      end
    endfunction

    function void check_report(tag_report_t got);
      tag_report_t exp;
      if (pending_reports.size() == 0) begin
        $error("report with none pending: tag_value %h", got.tag_value);
        errors++;
        return;
      end
      exp = pending_reports.pop_front();
      reports_seen++;
      if (exp.match_index != 0) matched++;
      if (!exp.check_ok) bad_check++;
      if (exp.digit_error) digit_errs++;
      if (got.tag_value !== exp.tag_value) begin
        $error("tag_value: expected %h, got %h", exp.tag_value, got.tag_value);
        errors++;
      end
      if (got.received_check !== exp.received_check) begin
        $error("received_check: expected %h, got %h", exp.received_check, got.received_check);
        errors++;
      end
      if (got.check_ok !== exp.check_ok) begin
        $error("check_ok: expected %b, got %b", exp.check_ok, got.check_ok);
        errors++;
      end
      if (got.match_index !== exp.match_index) begin
        $error("match_index: expected %0d, got %0d", exp.match_index, got.match_index);
        errors++;
      end
      if (got.digit_error !== exp.digit_error) begin
        $error("digit_error: expected %b, got %b", exp.digit_error, got.digit_error);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [TAG_W-1:0]     tag_value_o;
  logic [BYTE_W-1:0]    received_check_o;
  logic                 check_ok_o;
  logic [IDX_W-1:0]     match_index_o;
  logic                 digit_error_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TAG_W-1:0]     cfg_data_i = '0;

  frame_scoreboard sb = new();
  bit              send_gaps = 1'b1;
  bit              stall_gaps = 1'b1;
  bit              hold_req = 1'b0;
  int unsigned     bytes_in = 0;
  int unsigned     cycles = 0;

  rfid_ascii_hex_frame_matcher_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .rx_byte_i       (rx_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .tag_value_o     (tag_value_o),
    .received_check_o(received_check_o),
    .check_ok_o      (check_ok_o),
    .match_index_o   (match_index_o),
    .digit_error_o   (digit_error_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  // clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports pending", cycles,
               sb.pending_reports.size());
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall bursts plus one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (stall_gaps && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    tag_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.tag_value      = tag_value_o;
      got.received_check = received_check_o;
      got.check_ok       = check_ok_o;
      got.match_index    = match_index_o;
      got.digit_error    = digit_error_o;
      sb.check_report(got);
    end
  end

  // offer one item, hold it until taken
  task automatic put_byte(input logic [BYTE_W-1:0] b);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b);
    bytes_in++;
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TAG_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // whole table rewrite, optionally with writes to unused indexes
  task automatic load_table(input logic [TAG_W-1:0] count_word,
                            input logic [TAG_W-1:0] t [NUM_TAG_REGS], input bit junk);
    put_reg(CFG_TAG_COUNT, count_word);
    put_reg(CFG_TAG_A, t[0]);
    put_reg(CFG_TAG_B, t[1]);
    put_reg(CFG_TAG_C, t[2]);
    put_reg(CFG_TAG_D, t[3]);
    if (junk) begin
      repeat (3) begin
        put_reg(CFG_IDX_W'($urandom_range(CFG_TAG_D + 1, CFG_IDX_MAX)),
                {8'($urandom), $urandom});
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  // stop offering, wait until every report is in, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // STX, twelve digits; optional wrong checksum, one bad digit, or a cut
  task automatic send_frame(input logic [TAG_W-1:0] tag, input bit wrong_check,
                            input int bad_pos, input int cut_pos);
    logic [BYTE_W-1:0]       chk;
    logic [TAG_W+BYTE_W-1:0] bits;
    logic [3:0]              nib;
    logic [BYTE_W-1:0]       digits [DIGITS_PER_FRAME];
    logic [BYTE_W-1:0]       bad;
    chk = tag[39:32] ^ tag[31:24] ^ tag[23:16] ^ tag[15:8] ^ tag[7:0];
    if (wrong_check) chk = chk ^ 8'($urandom_range(1, 255));
    bits = {tag, chk};
    for (int i = 0; i < DIGITS_PER_FRAME; i++) begin
      nib = bits[4*(DIGITS_PER_FRAME-1-i) +: 4];
      digits[i] = (nib < 10) ? 8'(ASCII_ZERO + nib) : 8'(ASCII_A_UP + nib - 4'd10);
    end
    if (bad_pos >= 0) begin
      if ($urandom_range(0, 1)) begin
        bad = 8'($urandom_range(ASCII_A_LO, ASCII_F_LO));
      end else begin
        do begin
          bad = 8'($urandom_range(0, 255));
        end while ((bad >= ASCII_ZERO && bad <= ASCII_NINE) ||
                   (bad >= ASCII_A_UP && bad <= ASCII_F_UP) ||
                   bad == ASCII_CR || bad == ASCII_LF || bad == ASCII_ETX ||
                   bad == ASCII_STX);
      end
      digits[bad_pos] = bad;
    end
    put_byte(ASCII_STX);
    for (int i = 0; i < DIGITS_PER_FRAME; i++) begin
      if (i == cut_pos) begin
        put_byte(FRAME_STOPS[$urandom_range(0, 3)]);
        return;
      end
      put_byte(digits[i]);
    end
  endtask

  // mostly well-formed frames, tags often from the live table
  task automatic run_frames(input int unsigned budget);
    int unsigned      stop_at;
    logic [TAG_W-1:0] tag;
    logic [BYTE_W-1:0] b;
    int               pick;
    stop_at = bytes_in + budget;
    while (bytes_in < stop_at) begin
      // idle noise, never a header
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b = 8'($urandom_range(0, 255));
          if (b == ASCII_STX) b = ~ASCII_STX;
          put_byte(b);
        end
      end
      pick = $urandom_range(0, 9);
      if (pick <= 4) tag = sb.allowed[$urandom_range(0, NUM_TAG_REGS - 1)];
      else if (pick == 5) tag = '0;
      else if (pick == 6) tag = '1;
      else if (pick == 7) begin
        tag = sb.allowed[$urandom_range(0, NUM_TAG_REGS - 1)];
        tag[$urandom_range(0, TAG_W - 1)] ^= 1'b1;
      end else tag = {8'($urandom), $urandom};
      send_frame(tag, $urandom_range(0, 5) == 0,
                 ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 11)) : -1,
                 ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 11)) : -1);
    end
  endtask

  // stimulus
  initial begin
    logic [TAG_W-1:0] t [NUM_TAG_REGS];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ignored bytes, an abort, a good frame of entry a, header inside a frame
    put_byte('1);
    put_byte('0);
    put_byte(ASCII_STX);
    put_byte(ASCII_ZERO);
    put_byte(ASCII_CR);
    send_frame(TAG_RESET[0], 1'b0, -1, -1);
    put_byte(ASCII_STX);
    put_byte(ASCII_F_UP);
    put_byte(ASCII_STX);
    put_byte(ASCII_NINE);
    run_frames(PHASE_BYTES);
    settle();

    // full random table, receiver holds off for a long stretch
    foreach (t[i]) t[i] = {8'($urandom), $urandom};
    load_table(TAG_W'(TAG_COUNT_RESET), t, 1'b0);
    hold_req = 1'b1;
    run_frames(PHASE_BYTES);
    settle();

    // oversized count, extreme tags, duplicate entries, no result stalls
    t = '{'0, '1, {8'($urandom), $urandom}, '1};
    load_table('1, t, 1'b0);
    stall_gaps = 1'b0;
    run_frames(PHASE_BYTES);
    settle();

    // matching disabled, no idling anywhere
    foreach (t[i]) t[i] = {8'($urandom), $urandom};
    load_table('0, t, 1'b0);
    send_gaps = 1'b0;
    run_frames(PHASE_BYTES);
    settle();

    // single entry, junk in the upper count bits, writes to unused indexes
    send_gaps = 1'b1;
    stall_gaps = 1'b1;
    foreach (t[i]) t[i] = {8'($urandom), $urandom};
    load_table({{(TAG_W - CNT_W){1'b1}}, CNT_W'(1)}, t, 1'b1);
    run_frames(PHASE_BYTES);
    settle();

    // two entries, a and b equal
    t[0] = {8'($urandom), $urandom};
    t[1] = t[0];
    t[2] = {8'($urandom), $urandom};
    t[3] = {8'($urandom), $urandom};
    load_table(TAG_W'(2), t, 1'b0);
    run_frames(PHASE_BYTES);
    settle();

    // three entries
    foreach (t[i]) t[i] = {8'($urandom), $urandom};
    load_table(TAG_W'(3), t, 1'b1);
    run_frames(PHASE_BYTES);
    settle();

    // back to the default table, random count, no idling to the end
    send_gaps = 1'b0;
    stall_gaps = 1'b0;
    t = TAG_RESET;
    load_table({8'($urandom), $urandom}, t, 1'b0);
    run_frames(PHASE_BYTES);
    settle();

    $display("run: %0d bytes in, %0d frame reports (%0d matched, %0d bad checksum, %0d bad digit)",
             bytes_in, sb.reports_seen, sb.matched, sb.bad_check, sb.digit_errs);
    $display("run: %0d frames cut short, table counts 0 to 7 with repeated and extreme entries",
             sb.aborts);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rfidhx_pkg.sv
rtl/core/rfidhx_frame.sv
rtl/core/rfidhx_match.sv
rtl/core/rfid_ascii_hex_frame_matcher_core.sv
rtl/core/rfidhx_checker.sv
bench/rfid_ascii_hex_frame_matcher_core_tb.sv
